### hdl/cfb_pkg.sv
// Shared types and constants for the command frame builder.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package cfb_pkg;

    localparam int MAX_DATA_BYTES = 4090;
    localparam int SEEN_W         = 13;
    localparam int SEEN_MAX       = 8191;
    localparam int HDR_BYTES      = 3;
    localparam int GROUP_BYTES    = 4;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] PREFIX_BYTE = 8'h01;

    typedef enum logic [1:0] {
        STAT_GOOD     = 2'd0,
        STAT_SHORT    = 2'd1,
        STAT_LEN_BIG  = 2'd2,
        STAT_TOO_LONG = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        status_t    status;
        logic       out_last;
    } out_t;

    // One classified command byte, passed from the front end to the back end.
    typedef struct packed {
        logic        push;
        logic [7:0]  data_byte;
        logic        last;
        status_t     stat;
        logic [15:0] sum;
    } cmd_t;

endpackage

`default_nettype wire

### hdl/command_frame_builder.sv
// Command frame builder top level: front end, request queue, back end.
// Depends on cfb_pkg, cfb_front, cfb_queue and cfb_back.
//
// Usage:
//   s_* : one command byte per request (type, length hi, length lo, data...),
//         in_last set on the final byte of the command.
//   m_* : frame bytes (prefix 1, header, data, checksum hi/lo, zero pad),
//         emitted in 4-byte groups with each group byte-reversed, then one
//         status request (is_status=1, out_last=1). Nonzero status = drop frame.
// Throughput: one input request per cycle while the queue is not full; output
//   at most one request per cycle. After a last byte the back end pushes the
//   two checksum bytes and up to three pad bytes, then waits for the last group
//   to drain before the status request; the 4-entry queue takes input meanwhile.
// Output path: the request that fills a group is written to the queue, moved
//   into the drain register, then its first byte goes to the output register.
// Reset (aresetn low, synchronous): queue empty, counters cleared, group
//   buffer holds the prefix byte, no output valid.
// Receiver stall: the output register holds; the back end stops draining,
//   the queue fills, and s_ready drops once the queue (4 entries) is full.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_builder #(
    parameter int MAX_DATA_BYTES = cfb_pkg::MAX_DATA_BYTES
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  cfb_pkg::in_t    s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output cfb_pkg::out_t   m_data
);

    cfb_pkg::cmd_t q_wdata;
    cfb_pkg::cmd_t q_rdata;
    logic          q_wr;
    logic          q_rd;
    logic          q_full;
    logic          q_empty;

    // classify each command byte: push or drop, checksum, final status
    cfb_front #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_wr    (q_wr),
        .q_data  (q_wdata),
        .q_full  (q_full)
    );

    // decouples input acceptance from output stalls
    cfb_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (q_wr),
        .wdata   (q_wdata),
        .full    (q_full),
        .rd      (q_rd),
        .rdata   (q_rdata),
        .empty   (q_empty)
    );

    // group packing, reversal, trailer and status
    cfb_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_rd    (q_rd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

### hdl/cfb_front.sv
// Front end: accepts command bytes, tracks header, length, checksum and errors.
// Depends on cfb_pkg; writes classified bytes into cfb_queue.
`timescale 1ns / 1ps
`default_nettype none

module cfb_front #(
    parameter int MAX_DATA_BYTES = cfb_pkg::MAX_DATA_BYTES
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  cfb_pkg::in_t       s_data,
    output logic               q_wr,
    output cfb_pkg::cmd_t      q_data,
    input  wire logic          q_full
);

    logic [cfb_pkg::SEEN_W-1:0] seen_reg, seen_next;
    logic [15:0]                decl_reg, decl_next;
    logic [15:0]                sum_reg, sum_next;
    cfb_pkg::status_t           err_reg, err_next;
    logic                       push;
    cfb_pkg::status_t           stat;
    logic                       accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_wr    = accept;

    always_comb begin
        seen_next = (seen_reg < cfb_pkg::SEEN_W'(cfb_pkg::SEEN_MAX))
                  ? seen_reg + cfb_pkg::SEEN_W'(1) : seen_reg;
        err_next  = err_reg;
        if (seen_next > cfb_pkg::SEEN_W'(MAX_DATA_BYTES + cfb_pkg::HDR_BYTES)) begin
            err_next = cfb_pkg::STAT_TOO_LONG;
        end
        decl_next = decl_reg;
        push      = 1'b0;
        if (err_next == cfb_pkg::STAT_GOOD) begin
            if (seen_reg < cfb_pkg::SEEN_W'(cfb_pkg::HDR_BYTES)) begin
                push = 1'b1;
                if (seen_reg == cfb_pkg::SEEN_W'(1)) begin
                    decl_next = {s_data.in_byte, 8'h00};
                end else if (seen_reg == cfb_pkg::SEEN_W'(2)) begin
                    decl_next = {decl_reg[15:8], s_data.in_byte};
                    if (decl_next > 16'(MAX_DATA_BYTES)) begin
                        err_next = cfb_pkg::STAT_LEN_BIG;
                    end
                end
            end else if (16'(seen_reg - cfb_pkg::SEEN_W'(cfb_pkg::HDR_BYTES)) < decl_reg) begin
                push = 1'b1;
            end
        end
        sum_next = sum_reg + (push ? {8'h00, s_data.in_byte} : 16'h0000);

        // status ranking: too long, fewer than 3 bytes, length too big, missing data
        if (err_next == cfb_pkg::STAT_TOO_LONG) begin
            stat = cfb_pkg::STAT_TOO_LONG;
        end else if (seen_next < cfb_pkg::SEEN_W'(cfb_pkg::HDR_BYTES)) begin
            stat = cfb_pkg::STAT_SHORT;
        end else if (err_next == cfb_pkg::STAT_LEN_BIG) begin
            stat = cfb_pkg::STAT_LEN_BIG;
        end else if (17'(seen_next) < ({1'b0, decl_next} + 17'(cfb_pkg::HDR_BYTES))) begin
            stat = cfb_pkg::STAT_SHORT;
        end else begin
            stat = cfb_pkg::STAT_GOOD;
        end

        q_data.push      = push;
        q_data.data_byte = s_data.in_byte;
        q_data.last      = s_data.in_last;
        q_data.stat      = stat;
        q_data.sum       = sum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            decl_reg <= '0;
            sum_reg  <= 16'(cfb_pkg::PREFIX_BYTE);
            err_reg  <= cfb_pkg::STAT_GOOD;
        end else if (accept) begin
            if (s_data.in_last) begin
                seen_reg <= '0;
                decl_reg <= '0;
                sum_reg  <= 16'(cfb_pkg::PREFIX_BYTE);
                err_reg  <= cfb_pkg::STAT_GOOD;
            end else begin
                seen_reg <= seen_next;
                decl_reg <= decl_next;
                sum_reg  <= sum_next;
                err_reg  <= err_next;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/cfb_queue.sv
// Small FIFO of classified command bytes between front and back end.
// Depends on cfb_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module cfb_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr,
    input  cfb_pkg::cmd_t      wdata,
    output logic               full,
    input  wire logic          rd,
    output cfb_pkg::cmd_t      rdata,
    output logic               empty
);

    cfb_pkg::cmd_t               mem_reg [cfb_pkg::QUEUE_DEPTH];
    logic [cfb_pkg::QPTR_W-1:0]  wptr_reg, rptr_reg;
    logic [cfb_pkg::QPTR_W:0]    cnt_reg;
    logic                        do_wr, do_rd;

    assign full  = (cnt_reg == (cfb_pkg::QPTR_W + 1)'(cfb_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (do_wr) begin
                wptr_reg <= wptr_reg + cfb_pkg::QPTR_W'(1);
            end
            if (do_rd) begin
                rptr_reg <= rptr_reg + cfb_pkg::QPTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                cnt_reg <= cnt_reg + (cfb_pkg::QPTR_W + 1)'(1);
            end else if (do_rd && !do_wr) begin
                cnt_reg <= cnt_reg - (cfb_pkg::QPTR_W + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

### hdl/cfb_back.sv
// Back end: packs bytes into 4-byte groups, appends checksum, padding and status,
// and drains each group byte-reversed into the output register. Depends on cfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfb_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_empty,
    input  cfb_pkg::cmd_t      q_data,
    output logic               q_rd,
    output logic               m_valid,
    input  wire logic          m_ready,
    output cfb_pkg::out_t      m_data
);

    typedef enum logic [4:0] {
        BK_DATA = 5'b00001,
        BK_HI   = 5'b00010,
        BK_LO   = 5'b00100,
        BK_PAD  = 5'b01000,
        BK_STAT = 5'b10000
    } bk_state_t;

    bk_state_t         st_reg, st_next;
    logic [7:0]        grp_reg [cfb_pkg::GROUP_BYTES];
    logic [1:0]        fill_reg;
    logic [7:0]        drn_reg [cfb_pkg::GROUP_BYTES];
    logic [2:0]        drn_left_reg;
    logic [15:0]       sum_reg;
    cfb_pkg::status_t  stat_reg;
    logic              m_valid_reg;
    cfb_pkg::out_t     m_data_reg;

    logic              out_load, drn_emit, drn_ok, push_ok;
    logic              push_en, stat_emit, grp_done;
    logic [7:0]        push_byte;
    logic [1:0]        drn_idx;

    assign out_load = !m_valid_reg || m_ready;
    assign drn_emit = (drn_left_reg != 3'd0) && out_load;
    // drain frees up this cycle: empty, or its last byte is going out now
    assign drn_ok   = (drn_left_reg == 3'd0) || ((drn_left_reg == 3'd1) && out_load);
    assign push_ok  = (fill_reg != 2'd3) || drn_ok;
    assign drn_idx  = 2'(drn_left_reg - 3'd1);
    assign grp_done = push_en && (fill_reg == 2'd3);

    always_comb begin
        st_next   = st_reg;
        q_rd      = 1'b0;
        push_en   = 1'b0;
        push_byte = 8'h00;
        stat_emit = 1'b0;
        case (st_reg)
            BK_DATA: begin
                if (!q_empty && (!q_data.push || push_ok)) begin
                    q_rd      = 1'b1;
                    push_en   = q_data.push;
                    push_byte = q_data.data_byte;
                    if (q_data.last) begin
                        st_next = (q_data.stat == cfb_pkg::STAT_GOOD) ? BK_HI : BK_STAT;
                    end
                end
            end
            BK_HI: begin
                if (push_ok) begin
                    push_en   = 1'b1;
                    push_byte = sum_reg[15:8];
                    st_next   = BK_LO;
                end
            end
            BK_LO: begin
                if (push_ok) begin
                    push_en   = 1'b1;
                    push_byte = sum_reg[7:0];
                    st_next   = (fill_reg == 2'd3) ? BK_STAT : BK_PAD;
                end
            end
            BK_PAD: begin
                if (push_ok) begin
                    push_en = 1'b1;
                    if (fill_reg == 2'd3) begin
                        st_next = BK_STAT;
                    end
                end
            end
            BK_STAT: begin
                if ((drn_left_reg == 3'd0) && out_load) begin
                    stat_emit = 1'b1;
                    st_next   = BK_DATA;
                end
            end
            default: begin
                st_next = BK_DATA;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= BK_DATA;
            fill_reg     <= 2'd1;
            drn_left_reg <= 3'd0;
            m_valid_reg  <= 1'b0;
            grp_reg[0]   <= cfb_pkg::PREFIX_BYTE;
        end else begin
            st_reg <= st_next;
            if (stat_emit) begin
                grp_reg[0] <= cfb_pkg::PREFIX_BYTE;
                fill_reg   <= 2'd1;
            end else if (push_en) begin
                grp_reg[fill_reg] <= push_byte;
                fill_reg          <= fill_reg + 2'd1;
            end
            if (grp_done) begin
                drn_left_reg <= 3'(cfb_pkg::GROUP_BYTES);
            end else if (drn_emit) begin
                drn_left_reg <= drn_left_reg - 3'd1;
            end
            if (out_load) begin
                m_valid_reg <= drn_emit || stat_emit;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (grp_done) begin
            drn_reg[0] <= grp_reg[0];
            drn_reg[1] <= grp_reg[1];
            drn_reg[2] <= grp_reg[2];
            drn_reg[3] <= push_byte;
        end
        if (q_rd && q_data.last) begin
            sum_reg  <= q_data.sum;
            stat_reg <= q_data.stat;
        end
        if (out_load) begin
            if (drn_emit) begin
                m_data_reg.out_byte  <= drn_reg[drn_idx];
                m_data_reg.is_status <= 1'b0;
                m_data_reg.status    <= cfb_pkg::STAT_GOOD;
                m_data_reg.out_last  <= 1'b0;
            end else begin
                m_data_reg.out_byte  <= 8'h00;
                m_data_reg.is_status <= 1'b1;
                m_data_reg.status    <= stat_reg;
                m_data_reg.out_last  <= 1'b1;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for command_frame_builder: a clocked driver, a clocked monitor
// and a frame predictor that tracks each command's bytes, checksum and status.
// Depends on cfb_pkg and the command_frame_builder RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, fills the request queue
    localparam int DRAIN_CYCLES = 40;    // settle time after the last expected request
    localparam int IDLE_PCT     = 6;
    localparam int RANDOM_ITEMS = 310;
    localparam int MAX_REPORTS  = 10;

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    cfb_pkg::in_t  s_data  = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    cfb_pkg::out_t m_data;

    command_frame_builder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Command bytes waiting to be offered, and frame requests still owed by the block.
    cfb_pkg::in_t  cmd_q[$];
    cfb_pkg::out_t frame_q[$];

    int            directed_cnt = 0;
    int            accepted_cnt = 0;
    int            mismatch_cnt = 0;
    int            cycle_cnt    = 0;
    int            hold_left    = 0;
    int            holds_done   = 0;
    cfb_pkg::out_t want;

    // Both sides run without idle cycles for a stretch early in the random part.
    logic calm_stretch;
    assign calm_stretch = (accepted_cnt >= directed_cnt + 50) &&
                          (accepted_cnt <  directed_cnt + 150);

    // ------------------------------------------------------------------
    // Frame predictor state: one command in flight at a time.
    // ------------------------------------------------------------------
    logic [7:0]        grp_buf[4];
    int                grp_fill;
    int                seen_cnt;     // input bytes of this command, saturating
    int                len_field;    // declared data length from the header
    logic [15:0]       csum;         // wrapping additive checksum, prefix included
    cfb_pkg::status_t  err_code;     // STAT_GOOD while no error has been seen

    task automatic clear_frame_state();
        grp_buf   = '{cfb_pkg::PREFIX_BYTE, 8'h00, 8'h00, 8'h00};
        grp_fill  = 1;
        seen_cnt  = 0;
        len_field = 0;
        csum      = 16'(cfb_pkg::PREFIX_BYTE);
        err_code  = cfb_pkg::STAT_GOOD;
    endtask

    // Collect a byte into the current group; a full group goes out byte-reversed.
    task automatic pack_byte(input logic [7:0] b);
        cfb_pkg::out_t item;
        int            i;
        grp_buf[grp_fill] = b;
        grp_fill++;
        if (grp_fill == cfb_pkg::GROUP_BYTES) begin
            for (i = cfb_pkg::GROUP_BYTES - 1; i >= 0; i--) begin
                item          = '0;
                item.out_byte = grp_buf[i];
                frame_q.push_back(item);
            end
            grp_buf  = '{8'h00, 8'h00, 8'h00, 8'h00};
            grp_fill = 0;
        end
    endtask

    task automatic predict_frame(input cfb_pkg::in_t req);
        int               prev;
        cfb_pkg::status_t verdict;
        cfb_pkg::out_t    stat_item;
        prev = seen_cnt;
        if (seen_cnt < cfb_pkg::SEEN_MAX)
            seen_cnt++;
        if (seen_cnt > cfb_pkg::MAX_DATA_BYTES + cfb_pkg::HDR_BYTES)
            err_code = cfb_pkg::STAT_TOO_LONG;

        if (err_code == cfb_pkg::STAT_GOOD) begin
            if (prev < cfb_pkg::HDR_BYTES) begin
                csum = csum + req.in_byte;
                pack_byte(req.in_byte);
                if (prev == 1) begin
                    len_field = int'(req.in_byte) << 8;
                end else if (prev == 2) begin
                    len_field = len_field | int'(req.in_byte);
                    if (len_field > cfb_pkg::MAX_DATA_BYTES)
                        err_code = cfb_pkg::STAT_LEN_BIG;
                end
            end else if (prev - cfb_pkg::HDR_BYTES < len_field) begin
                csum = csum + req.in_byte;
                pack_byte(req.in_byte);
            end
            // surplus data past the declared length is dropped
        end

        if (req.in_last) begin
            // ranking: too long, under 3 bytes, length too big, missing data
            if (err_code == cfb_pkg::STAT_TOO_LONG)
                verdict = cfb_pkg::STAT_TOO_LONG;
            else if (seen_cnt < cfb_pkg::HDR_BYTES)
                verdict = cfb_pkg::STAT_SHORT;
            else if (err_code == cfb_pkg::STAT_LEN_BIG)
                verdict = cfb_pkg::STAT_LEN_BIG;
            else if (seen_cnt < len_field + cfb_pkg::HDR_BYTES)
                verdict = cfb_pkg::STAT_SHORT;
            else
                verdict = cfb_pkg::STAT_GOOD;

            // checksum and padding only on a good frame
            if (verdict == cfb_pkg::STAT_GOOD) begin
                pack_byte(csum[15:8]);
                pack_byte(csum[7:0]);
                while (grp_fill != 0)
                    pack_byte(8'h00);
            end
            stat_item           = '0;
            stat_item.is_status = 1'b1;
            stat_item.status    = verdict;
            stat_item.out_last  = 1'b1;
            frame_q.push_back(stat_item);
            clear_frame_state();
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    // Header (type, length hi, length lo) then ndata random data bytes.
    task automatic add_command(input logic [7:0] ctype, input int len, input int ndata);
        cfb_pkg::in_t req;
        int           i;
        req.in_last = 1'b0;
        req.in_byte = ctype;
        cmd_q.push_back(req);
        req.in_byte = len[15:8];
        cmd_q.push_back(req);
        req.in_byte = len[7:0];
        req.in_last = (ndata == 0);
        cmd_q.push_back(req);
        for (i = 0; i < ndata; i++) begin
            req.in_byte = 8'($urandom);
            req.in_last = (i == ndata - 1);
            cmd_q.push_back(req);
        end
    endtask

    // Command cut off inside the header.
    task automatic add_stub(input int nbytes);
        cfb_pkg::in_t req;
        int           i;
        for (i = 0; i < nbytes; i++) begin
            req.in_byte = 8'($urandom);
            req.in_last = (i == nbytes - 1);
            cmd_q.push_back(req);
        end
    endtask

    task automatic add_random_commands();
        int r;
        int len;
        while (cmd_q.size() - directed_cnt < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 70) begin
                // well-formed, mostly short, now and then longer
                len = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12);
                add_command(8'($urandom), len, len);
            end else if (r < 78) begin
                len = $urandom_range(6);
                add_command(8'($urandom), len, len + $urandom_range(1, 4));
            end else if (r < 86) begin
                len = $urandom_range(1, 10);
                add_command(8'($urandom), len, $urandom_range(len - 1));
            end else if (r < 92) begin
                add_command(8'($urandom),
                            $urandom_range(cfb_pkg::MAX_DATA_BYTES + 1, 65535),
                            $urandom_range(4));
            end else begin
                add_stub($urandom_range(1, 2));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued command bytes, predicts on each accepted request.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_frame(s_data);
                accepted_cnt <= accepted_cnt + 1;
            end
            // slot is free when nothing is offered or the offer was just taken
            if (!s_valid || s_ready) begin
                if (cmd_q.size() != 0 &&
                    (calm_stretch || $urandom_range(99) >= IDLE_PCT)) begin
                    s_data  <= cmd_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks accepted frame requests in order, drives m_ready.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (frame_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected request byte=%h st=%b stat=%0d last=%b",
                                 $time, m_data.out_byte, m_data.is_status,
                                 m_data.status, m_data.out_last);
                end else begin
                    want = frame_q.pop_front();
                    if (m_data.out_byte  !== want.out_byte  ||
                        m_data.is_status !== want.is_status ||
                        m_data.status    !== want.status    ||
                        m_data.out_last  !== want.out_last) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display({"%0t: mismatch exp byte=%h st=%b stat=%0d last=%b,",
                                      " got byte=%h st=%b stat=%0d last=%b"},
                                     $time, want.out_byte, want.is_status, want.status,
                                     want.out_last, m_data.out_byte, m_data.is_status,
                                     m_data.status, m_data.out_last);
                    end
                end
            end

            // Two long hold-offs in the random part. The sender keeps
            // offering, so s_ready must drop.
            if (hold_left != 0) begin
                m_ready   <= 1'b0;
                hold_left <= hold_left - 1;
            end else if ((holds_done == 0 && accepted_cnt >= directed_cnt + 170) ||
                         (holds_done == 1 && accepted_cnt >= directed_cnt + 260)) begin
                m_ready    <= 1'b0;
                hold_left  <= HOLD_CYCLES - 1;
                holds_done <= holds_done + 1;
            end else begin
                m_ready <= calm_stretch || ($urandom_range(99) >= IDLE_PCT);
            end
        end else begin
            m_ready <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        clear_frame_state();

        // header cut short: one byte, two bytes
        add_stub(1);
        add_stub(2);
        // good frames, every padding amount, type extremes
        add_command(8'h00, 0, 0);
        add_command(8'hFF, 1, 1);
        add_command(8'hA5, 2, 2);
        add_command(8'h5A, 3, 3);
        add_command(8'h3C, 4, 4);
        // missing data and surplus data
        add_command(8'h11, 6, 3);
        add_command(8'h22, 2, 7);
        // length field just over the limit, and all ones
        add_command(8'h33, cfb_pkg::MAX_DATA_BYTES + 1, 2);
        add_command(8'h44, 16'hFFFF, 0);
        // a longer legal frame spanning many groups
        add_command(8'h7E, 40, 40);
        directed_cnt = cmd_q.size();

        add_random_commands();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_q.size() != 0 || s_valid)
            @(posedge aclk);
        while (frame_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
